// File: rtl/core/utv_pkg.sv
// ----------------------------------------------------------------------------
// utv_pkg
// shared types and constants of the utf-8 text validator
// ----------------------------------------------------------------------------
package utv_pkg;

  localparam int unsigned CpW = 21;

  // item kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // sequence length classes (continuations in the current sequence)
  localparam logic [1:0] ClsNone  = 2'd0;
  localparam logic [1:0] ClsTwo   = 2'd1;
  localparam logic [1:0] ClsThree = 2'd2;
  localparam logic [1:0] ClsFour  = 2'd3;

  localparam logic [7:0] AsciiDel  = 8'h7f;
  localparam logic [7:0] Lead2Lo   = 8'hc2;
  localparam logic [7:0] Lead2Hi   = 8'hdf;
  localparam logic [7:0] Lead3Lo   = 8'he0;
  localparam logic [7:0] Lead3Hi   = 8'hef;
  localparam logic [7:0] Lead4Lo   = 8'hf0;
  localparam logic [7:0] Lead4Hi   = 8'hf4;

  localparam logic [CpW-1:0] CpMax      = 21'h10ffff;
  localparam logic [CpW-1:0] SurrLo     = 21'h00d800;
  localparam logic [CpW-1:0] SurrHi     = 21'h00dfff;
  localparam logic [CpW-1:0] CtlLo      = 21'h000080;
  localparam logic [CpW-1:0] CtlHi      = 21'h00009f;
  localparam logic [CpW-1:0] ZwLo       = 21'h00200b;
  localparam logic [CpW-1:0] ZwHi       = 21'h00200f;
  localparam logic [CpW-1:0] BidiLo     = 21'h002028;
  localparam logic [CpW-1:0] BidiHi     = 21'h00202e;
  localparam logic [CpW-1:0] InvisLo    = 21'h002060;
  localparam logic [CpW-1:0] InvisHi    = 21'h00206f;
  localparam logic [CpW-1:0] Bom        = 21'h00feff;
  localparam logic [CpW-1:0] Min2       = 21'h000080;
  localparam logic [CpW-1:0] Min3       = 21'h000800;
  localparam logic [CpW-1:0] Min4       = 21'h010000;

  typedef struct packed {
    logic           err;
    logic [1:0]     pend;
    logic [1:0]     cls;
    logic [CpW-1:0] acc;
  } dec_state_t;

endpackage

// File: rtl/core/utv_decode.sv
// ----------------------------------------------------------------------------
// utv_decode
// next decoder state for one text byte
// ----------------------------------------------------------------------------
module utv_decode (
  input  utv_pkg::dec_state_t cur_i,
  input  logic [7:0]          text_byte_i,
  output utv_pkg::dec_state_t nxt_o
);

  logic [utv_pkg::CpW-1:0] cp;
  logic [utv_pkg::CpW-1:0] cp_min;
  logic                    cp_bad;

  assign cp = {cur_i.acc[utv_pkg::CpW-7:0], text_byte_i[5:0]};

  always_comb begin
    case (cur_i.cls)
      utv_pkg::ClsTwo:   cp_min = utv_pkg::Min2;
      utv_pkg::ClsThree: cp_min = utv_pkg::Min3;
      default:           cp_min = utv_pkg::Min4;
    endcase
  end

  assign cp_bad = (cp < cp_min) || (cp > utv_pkg::CpMax)
               || (cp >= utv_pkg::SurrLo  && cp <= utv_pkg::SurrHi)
               || (cp >= utv_pkg::CtlLo   && cp <= utv_pkg::CtlHi)
               || (cp >= utv_pkg::ZwLo    && cp <= utv_pkg::ZwHi)
               || (cp >= utv_pkg::BidiLo  && cp <= utv_pkg::BidiHi)
               || (cp >= utv_pkg::InvisLo && cp <= utv_pkg::InvisHi)
               || (cp == utv_pkg::Bom);

  always_comb begin
    nxt_o = cur_i;
    if (!cur_i.err) begin
      if (cur_i.pend == 2'd0) begin
        if (!text_byte_i[7]) begin
          // ascii controls, nul and del
          if (text_byte_i < 8'h20 || text_byte_i == utv_pkg::AsciiDel) begin
            nxt_o.err = 1'b1;
          end
        end else if (text_byte_i >= utv_pkg::Lead2Lo && text_byte_i <= utv_pkg::Lead2Hi) begin
          nxt_o.pend = 2'd1;
          nxt_o.cls  = utv_pkg::ClsTwo;
          nxt_o.acc  = {16'd0, text_byte_i[4:0]};
        end else if (text_byte_i >= utv_pkg::Lead3Lo && text_byte_i <= utv_pkg::Lead3Hi) begin
          nxt_o.pend = 2'd2;
          nxt_o.cls  = utv_pkg::ClsThree;
          nxt_o.acc  = {17'd0, text_byte_i[3:0]};
        end else if (text_byte_i >= utv_pkg::Lead4Lo && text_byte_i <= utv_pkg::Lead4Hi) begin
          nxt_o.pend = 2'd3;
          nxt_o.cls  = utv_pkg::ClsFour;
          nxt_o.acc  = {18'd0, text_byte_i[2:0]};
        end else begin
          nxt_o.err = 1'b1;
        end
      end else if (text_byte_i[7:6] != 2'b10) begin
        // bad continuation drops the sequence
        nxt_o.err  = 1'b1;
        nxt_o.pend = 2'd0;
      end else begin
        nxt_o.acc  = cp;
        nxt_o.pend = cur_i.pend - 2'd1;
        if (cur_i.pend == 2'd1 && cp_bad) begin
          nxt_o.err = 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/utf8_text_validator_top.sv
// ----------------------------------------------------------------------------
// utf8_text_validator_top
// utf-8 text validator: one verdict per text, given at the end marker
// ----------------------------------------------------------------------------
//  channel  signals                                dir  carries
//  in       in_valid_i in_ready_o kind_i text_byte_i in  one byte or end marker
//  out      out_valid_o out_ready_i text_ok_o       out  verdict per text
//
//  one request per cycle while in_ready_o is high; a byte updates the decoder
//  state at the edge it is taken, an end marker loads the verdict register at
//  that edge and the verdict is offered from the next cycle on
//  bytes are never stalled; an end marker waits only while an untaken
//  verdict sits in the output register and out_ready_i is low
//  reset clears the decoder state, the byte count and the output valid
// ----------------------------------------------------------------------------
module utf8_text_validator_top #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic kind_i,
  input  logic [7:0] text_byte_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic text_ok_o
);

  localparam int unsigned CntW = $clog2(MAX_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BYTES);

  utv_pkg::dec_state_t st_q, st_d, dec_nxt;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                text_ok_q, text_ok_d;
  logic                in_fire;

  utv_decode u_decode (
    .cur_i       (st_q),
    .text_byte_i (text_byte_i),
    .nxt_o       (dec_nxt)
  );

  assign in_ready_o = (kind_i == utv_pkg::KindByte) || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    text_ok_d   = text_ok_q;
    if (in_fire) begin
      if (kind_i == utv_pkg::KindByte) begin
        st_d = dec_nxt;
        if (cnt_q != CntMax) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        out_valid_d = 1'b1;
        text_ok_d   = !st_q.err && (st_q.pend == 2'd0)
                   && (cnt_q != '0) && (cnt_q != CntMax);
        st_d        = '0;
        cnt_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    text_ok_q <= text_ok_d;
  end

  assign out_valid_o = out_valid_q;
  assign text_ok_o   = text_ok_q;

endmodule

// File: rtl/core/utv_checker.sv
// ----------------------------------------------------------------------------
// utv_checker
// port-level checks of the utf-8 text validator
// ----------------------------------------------------------------------------
module utv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic kind_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic text_ok_o
);

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(text_ok_o))
    else $error("verdict dropped or changed while stalled");

  // a verdict appears only after an accepted end marker
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && kind_i))
    else $error("verdict without end marker");

  // every accepted end marker yields a verdict next cycle
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i |=> out_valid_o)
    else $error("end marker without verdict");

  // text bytes are never held off
  a_byte_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !kind_i |-> in_ready_o)
    else $error("byte request stalled");

endmodule

bind utf8_text_validator_top utv_checker u_utv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .text_ok_o   (text_ok_o)
);
